### rtl/core/skhe_pkg.sv
// Package for the string key hash block: request codes, token format for the
// cell row, controller states and hash constants. No dependencies.
`default_nettype none

package skhe_pkg;

   localparam int MAX_FORBIDDEN_DEF = 64;

   localparam logic [31:0] FNV_BASIS      = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME      = 32'h0100_0193;
   localparam logic [31:0] RANGE_CLAMP_AT = 32'hFFFF_FFFD;
   localparam logic [31:0] RANGE_CLAMP_TO = 32'hFFFF_FFFC;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_BYTE  = 2'd2,
      REQ_END   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      TOK_IDLE  = 2'd0,
      TOK_ADD   = 2'd1,
      TOK_COUNT = 2'd2,
      TOK_BUMP  = 2'd3
   } tok_op_type;

   typedef struct packed {
      tok_op_type  op;
      logic        carry;
      logic        done;
      logic        ins;
      logic        ovf;
      logic [31:0] data;
   } token_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_COUNT,
      ST_MUL,
      ST_BASE,
      ST_LAUNCH,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### rtl/core/skhe_if.sv
// Channel interfaces of the string key hash block: request, response and
// configuration write. Plain valid/ready transfer, no package dependency.
`default_nettype none

interface skhe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  key_byte;
   logic [31:0] forbidden_value;

   modport source (output valid, req_type, key_byte, forbidden_value, input ready);
   modport sink   (input valid, req_type, key_byte, forbidden_value, output ready);
endinterface

interface skhe_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hashed_key;
   logic        table_overflowed;

   modport source (output valid, hashed_key, table_overflowed, input ready);
   modport sink   (input valid, hashed_key, table_overflowed, output ready);
endinterface

interface skhe_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] reserved_range;

   modport source (output valid, reserved_range, input ready);
   modport sink   (input valid, reserved_range, output ready);
endinterface

`default_nettype wire

### rtl/core/skhe_cell.sv
// One cell of the forbidden key row: holds one sorted key and processes the
// token passing through it. Depends on skhe_pkg.
`default_nettype none

module skhe_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                occ,
   input  logic                full,
   input  logic [31:0]         reserved,
   input  skhe_pkg::token_type tok_up,
   output skhe_pkg::token_type tok_dn
);
   import skhe_pkg::*;

   logic [31:0] key_ff, key_in;
   token_type   tok_ff, tok_in;

   always_comb begin
      tok_in = tok_up;
      key_in = key_ff;
      case (tok_up.op)
         TOK_ADD: begin
            if (!tok_up.done) begin
               if (!occ) begin
                  // first free slot: place the pending key
                  key_in       = tok_up.data;
                  tok_in.carry = 1'b0;
                  tok_in.done  = 1'b1;
                  tok_in.ins   = 1'b1;
               end else if (tok_up.carry) begin
                  key_in      = tok_up.data;
                  tok_in.data = key_ff;
               end else if (key_ff == tok_up.data) begin
                  tok_in.done = 1'b1;
               end else if (key_ff > tok_up.data) begin
                  if (full) begin
                     tok_in.done = 1'b1;
                     tok_in.ovf  = 1'b1;
                  end else begin
                     key_in       = tok_up.data;
                     tok_in.data  = key_ff;
                     tok_in.carry = 1'b1;
                  end
               end
            end
         end
         TOK_COUNT: begin
            if (occ && key_ff <= reserved) begin
               tok_in.data = tok_up.data + 32'd1;
            end
         end
         TOK_BUMP: begin
            if (!tok_up.done && occ && key_ff > reserved) begin
               if (tok_up.data >= key_ff) begin
                  tok_in.data = tok_up.data + 32'd1;
               end else begin
                  tok_in.done = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign tok_dn = tok_ff;

endmodule

`default_nettype wire

### rtl/core/skhe_chain.sv
// Row of skhe_cell instances, one per table entry, with occupancy taken from
// the fill count. Depends on skhe_pkg and skhe_cell.
`default_nettype none

module skhe_chain #(
   parameter int MAX_FORBIDDEN = skhe_pkg::MAX_FORBIDDEN_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [$clog2(MAX_FORBIDDEN + 1) - 1:0]   count,
   input  logic [31:0]                              reserved,
   input  skhe_pkg::token_type                      tok_head,
   output skhe_pkg::token_type                      tok_tail
);
   import skhe_pkg::*;

   localparam int CW = $clog2(MAX_FORBIDDEN + 1);

   token_type tok_w [MAX_FORBIDDEN + 1];
   logic      full;

   assign full     = (count == CW'(MAX_FORBIDDEN));
   assign tok_w[0] = tok_head;
   assign tok_tail = tok_w[MAX_FORBIDDEN];

   for (genvar i = 0; i < MAX_FORBIDDEN; i++) begin : g_cell
      logic occ;
      assign occ = (CW'(i) < count);

      skhe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .occ      (occ),
         .full     (full),
         .reserved (reserved),
         .tok_up   (tok_w[i]),
         .tok_dn   (tok_w[i + 1])
      );
   end

endmodule

`default_nettype wire

### rtl/core/string_key_hash_with_exclusions.sv
// Top level of the string key hash block: FNV-1a hashing, controller and the
// forbidden key cell row. Depends on skhe_pkg, skhe_if.sv and skhe_chain.
`default_nettype none

// FNV-1a hashes key bytes and maps each finished key past the reserved range
// and around a sorted table of forbidden keys held in a row of MAX_FORBIDDEN
// cells. Key bytes and clears are handled in the idle state and leave the
// block idle. An add walks a token through the cell row; an end of key runs
// one walk to count the keys at or below the reserved range, a registered
// 32x32 multiply and offset add, and a second walk that bumps the result past
// forbidden keys. Items are taken one at a time; a response waiting in the
// output register holds back only the next end of key, which waits in its
// final state until the register is free.
// The reserved range may only be written while the block is idle.
module string_key_hash_with_exclusions #(
   parameter int MAX_FORBIDDEN = skhe_pkg::MAX_FORBIDDEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   skhe_req_if.sink   req_ch,
   skhe_rsp_if.source rsp_ch,
   skhe_csr_if.sink   csr_ch
);
   import skhe_pkg::*;

   localparam int CW = $clog2(MAX_FORBIDDEN + 1);

   state_type    state_ff, state_in;
   logic [31:0]  hash_ff, hash_in;
   logic [31:0]  fin_hash_ff, fin_hash_in;
   logic [31:0]  reserved_ff, reserved_in;
   logic [31:0]  avail_ff, avail_in;
   logic [31:0]  acc_ff, acc_in;
   logic [31:0]  rsp_key_ff, rsp_key_in;
   logic [CW-1:0] count_ff, count_in;
   logic         ovf_ff, ovf_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_ovf_ff, rsp_ovf_in;

   req_kind_type kind;
   logic         req_ready;
   logic         req_fire;
   logic         rsp_free;
   logic [31:0]  r_clamp;
   logic [31:0]  mixed;
   logic [63:0]  product;
   logic [CW-1:0] above_cnt;
   token_type    inj_tok;
   token_type    out_tok;

   assign kind     = req_kind_type'(req_ch.req_type);
   assign req_fire = req_ch.valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign r_clamp  = (reserved_ff >= RANGE_CLAMP_AT) ? RANGE_CLAMP_TO : reserved_ff;
   assign mixed    = hash_ff ^ {24'd0, req_ch.key_byte};
   assign product  = 64'(fin_hash_ff) * 64'(avail_ff);
   assign above_cnt = count_ff - out_tok.data[CW-1:0];

   skhe_chain #(
      .MAX_FORBIDDEN (MAX_FORBIDDEN)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .count    (count_ff),
      .reserved (r_clamp),
      .tok_head (inj_tok),
      .tok_tail (out_tok)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (kind)
                  REQ_ADD: state_in = ST_ADD;
                  REQ_END: state_in = ST_COUNT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (out_tok.op == TOK_ADD) state_in = ST_IDLE;
         end
         ST_COUNT: begin
            if (out_tok.op == TOK_COUNT) state_in = ST_MUL;
         end
         ST_MUL:    state_in = ST_BASE;
         ST_BASE:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_WALK;
         ST_WALK: begin
            if (out_tok.op == TOK_BUMP) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake and token injection
   always_comb begin
      req_ready = 1'b0;
      inj_tok   = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               case (kind)
                  REQ_ADD: begin
                     inj_tok.op   = TOK_ADD;
                     inj_tok.data = req_ch.forbidden_value;
                  end
                  REQ_END: begin
                     inj_tok.op = TOK_COUNT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LAUNCH: begin
            inj_tok.op   = TOK_BUMP;
            inj_tok.data = acc_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      hash_in      = hash_ff;
      fin_hash_in  = fin_hash_ff;
      reserved_in  = reserved_ff;
      avail_in     = avail_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_key_in   = rsp_key_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (csr_ch.valid) reserved_in = csr_ch.reserved_range;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (kind)
                  REQ_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  REQ_BYTE: begin
                     if (req_ch.key_byte != 8'd0) hash_in = mixed * FNV_PRIME;
                  end
                  REQ_END: begin
                     fin_hash_in = hash_ff;
                     hash_in     = FNV_BASIS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (out_tok.op == TOK_ADD) begin
               if (out_tok.ins) count_in = count_ff + CW'(1);
               if (out_tok.ovf || !out_tok.done) ovf_in = 1'b1;
            end
         end
         ST_COUNT: begin
            // 2^32 - (r + 1) - above = ~r - above
            if (out_tok.op == TOK_COUNT) avail_in = ~r_clamp - 32'(above_cnt);
         end
         ST_MUL:  acc_in = product[63:32];
         ST_BASE: acc_in = acc_ff + r_clamp + 32'd1;
         ST_WALK: begin
            if (out_tok.op == TOK_BUMP) acc_in = out_tok.data;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = acc_ff;
               rsp_ovf_in   = ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= FNV_BASIS;
         reserved_ff  <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         reserved_ff  <= reserved_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_hash_ff <= fin_hash_in;
      avail_ff    <= avail_in;
      acc_ff      <= acc_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_ch.ready            = req_ready;
   assign csr_ch.ready            = 1'b1;
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.hashed_key       = rsp_key_ff;
   assign rsp_ch.table_overflowed = rsp_ovf_ff;

endmodule

`default_nettype wire

### rtl/core/skhe_checker.sv
// Port-level assertions for the string key hash block, bound to the top
// level. Depends on skhe_pkg and string_key_hash_with_exclusions.
`default_nettype none

module skhe_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] hashed_key,
   input logic        table_overflowed
);
   import skhe_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(hashed_key) && $stable(table_overflowed))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_END |=> !req_ready)
      else $error("end of key transfer did not start finalisation");

   a_add_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_ADD |=> !req_ready)
      else $error("add transfer did not start table walk");

   a_fast_ops: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_BYTE || req_type == REQ_CLEAR)
         |=> req_ready)
      else $error("key byte or clear stalled the request channel");

endmodule

bind string_key_hash_with_exclusions skhe_assertions u_skhe_assertions (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_type         (req_ch.req_type),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .hashed_key       (rsp_ch.hashed_key),
   .table_overflowed (rsp_ch.table_overflowed)
);

`default_nettype wire
